### hdl/wsfd_pkg.sv
`timescale 1ns / 1ps

package wsfd_pkg;

    // Status codes carried on the frame's last result
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TRUNC      = 2'd1;
    localparam logic [1:0] ST_NOT_TEXT   = 2'd2;
    localparam logic [1:0] ST_NOT_MASKED = 2'd3;

    // Header field constants
    localparam logic [3:0] OPCODE_TEXT   = 4'h1;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [3:0] MASK_BYTES    = 4'd4;

    // One received byte of a chunk
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } item_t;

    // One decoded result
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_done;
        logic [1:0] status;
    } result_t;

endpackage

### hdl/wsfd_in_stage.sv
`timescale 1ns / 1ps

module wsfd_in_stage
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] data_byte,
    input  logic       chunk_last,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  item_valid_reg;
    item_t item_reg;
    logic  load;

    // Take a new request when the register is empty or moving on
    assign load     = !item_valid_reg || advance;
    assign rx_stall = !load;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            item_valid_reg <= rx_valid;
        end
    end

    // Capture the byte
    always_ff @(posedge clk)
    begin
        if (load && rx_valid)
        begin
            item_reg.data_byte  <= data_byte;
            item_reg.chunk_last <= chunk_last;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

### hdl/wsfd_parser.sv
`timescale 1ns / 1ps

module wsfd_parser
    import wsfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    input  logic    advance,
    output logic    has_result,
    output result_t result
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic        text_frame_reg, text_frame_next;
    logic        mask_present_reg, mask_present_next;
    logic [63:0] payload_length_reg, payload_length_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [63:0] bytes_remaining_reg, bytes_remaining_next;
    logic [1:0]  mask_position_reg, mask_position_next;

    logic        step;
    logic [7:0]  b;
    logic        last;
    logic [6:0]  len7;
    logic [3:0]  idx_dec;
    logic [3:0]  idx_inc;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;
    logic        hdr_text;
    logic        hdr_mask;

    assign step     = advance && item_valid;
    assign b        = item.data_byte;
    assign last     = item.chunk_last;
    assign len7     = b[6:0];
    assign idx_dec  = header_index_reg - 4'd1;
    assign idx_inc  = header_index_reg + 4'd1;
    assign rem_dec  = bytes_remaining_reg - 64'd1;
    // Key byte 0 sits in the top byte of the key register
    assign key_byte = mask_key_reg[{~mask_position_reg, 3'b000} +: 8];

    // Decode one byte against the current header state
    always_comb
    begin
        phase_next           = phase_reg;
        header_index_next    = header_index_reg;
        text_frame_next      = text_frame_reg;
        mask_present_next    = mask_present_reg;
        payload_length_next  = payload_length_reg;
        mask_key_next        = mask_key_reg;
        bytes_remaining_next = bytes_remaining_reg;
        mask_position_next   = mask_position_reg;
        has_result           = 1'b0;
        result               = '0;
        hdr_text             = text_frame_reg;
        hdr_mask             = mask_present_reg;

        unique case (phase_reg)
            PH_HDR0:
            begin
                text_frame_next      = (b[3:0] == OPCODE_TEXT);
                mask_present_next    = 1'b0;
                payload_length_next  = '0;
                mask_key_next        = '0;
                bytes_remaining_next = '0;
                mask_position_next   = '0;
                header_index_next    = '0;
                phase_next           = PH_HDR1;
                if (last)
                begin
                    has_result        = 1'b1;
                    result.frame_done = 1'b1;
                    result.status     = ST_TRUNC;
                    phase_next        = PH_HDR0;
                end
            end

            PH_HDR1:
            begin
                mask_present_next = b[7];
                hdr_mask          = b[7];
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                begin
                    header_index_next   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    payload_length_next = '0;
                    phase_next          = PH_EXTLEN;
                    if (last)
                    begin
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.status     = ST_TRUNC;
                        phase_next        = PH_HDR0;
                    end
                end
                else
                begin
                    payload_length_next = {57'd0, len7};
                    // Header complete: check opcode, then mask bit
                    if (!hdr_text || !hdr_mask || last)
                    begin
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.status     = !hdr_text ? ST_NOT_TEXT :
                                            (!hdr_mask ? ST_NOT_MASKED : ST_TRUNC);
                        phase_next        = last ? PH_HDR0 : PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_MASK;
                    end
                    if (hdr_text && hdr_mask)
                    begin
                        header_index_next = '0;
                    end
                end
            end

            PH_EXTLEN:
            begin
                payload_length_next = {payload_length_reg[55:0], b};
                header_index_next   = idx_dec;
                if (idx_dec == 4'd0)
                begin
                    if (!hdr_text || !hdr_mask || last)
                    begin
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.status     = !hdr_text ? ST_NOT_TEXT :
                                            (!hdr_mask ? ST_NOT_MASKED : ST_TRUNC);
                        phase_next        = last ? PH_HDR0 : PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_MASK;
                    end
                end
                else if (last)
                begin
                    has_result        = 1'b1;
                    result.frame_done = 1'b1;
                    result.status     = ST_TRUNC;
                    phase_next        = PH_HDR0;
                end
            end

            PH_MASK:
            begin
                mask_key_next     = {mask_key_reg[23:0], b};
                header_index_next = idx_inc;
                if (idx_inc >= MASK_BYTES)
                begin
                    bytes_remaining_next = payload_length_reg;
                    mask_position_next   = '0;
                    if (payload_length_reg == 64'd0)
                    begin
                        // Empty payload: done with ok status
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.status     = ST_OK;
                        phase_next        = last ? PH_HDR0 : PH_SKIP;
                    end
                    else if (last)
                    begin
                        has_result        = 1'b1;
                        result.frame_done = 1'b1;
                        result.status     = ST_TRUNC;
                        phase_next        = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                else if (last)
                begin
                    has_result        = 1'b1;
                    result.frame_done = 1'b1;
                    result.status     = ST_TRUNC;
                    phase_next        = PH_HDR0;
                end
            end

            PH_PAYLOAD:
            begin
                has_result = 1'b1;
                if (bytes_remaining_reg == 64'd0)
                begin
                    result.frame_done = 1'b1;
                    result.status     = ST_OK;
                    phase_next        = last ? PH_HDR0 : PH_SKIP;
                end
                else
                begin
                    mask_position_next   = mask_position_reg + 2'd1;
                    bytes_remaining_next = rem_dec;
                    if (rem_dec == 64'd0)
                    begin
                        // Last payload byte ends the frame
                        result.payload_byte = b ^ key_byte;
                        result.byte_valid   = 1'b1;
                        result.frame_done   = 1'b1;
                        result.status       = ST_OK;
                        phase_next          = last ? PH_HDR0 : PH_SKIP;
                    end
                    else if (last)
                    begin
                        result.frame_done = 1'b1;
                        result.status     = ST_TRUNC;
                        phase_next        = PH_HDR0;
                    end
                    else
                    begin
                        result.payload_byte = b ^ key_byte;
                        result.byte_valid   = 1'b1;
                    end
                end
            end

            default:
            begin
                // Drop trailing bytes until the chunk ends
                if (last)
                begin
                    phase_next = PH_HDR0;
                end
            end
        endcase
    end

    // Hold parser state; advance on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HDR0;
            header_index_reg    <= '0;
            text_frame_reg      <= 1'b0;
            mask_present_reg    <= 1'b0;
            payload_length_reg  <= '0;
            mask_key_reg        <= '0;
            bytes_remaining_reg <= '0;
            mask_position_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            header_index_reg    <= header_index_next;
            text_frame_reg      <= text_frame_next;
            mask_present_reg    <= mask_present_next;
            payload_length_reg  <= payload_length_next;
            mask_key_reg        <= mask_key_next;
            bytes_remaining_reg <= bytes_remaining_next;
            mask_position_reg   <= mask_position_next;
        end
    end

`ifndef SYNTHESIS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> phase_reg == PH_HDR0)
        else $error("chunk end did not return to first header byte");

    a_bad_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && result.status != ST_OK |-> !result.byte_valid && result.frame_done)
        else $error("bad status on a result carrying a byte");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && !result.byte_valid |-> result.payload_byte == 8'd0)
        else $error("payload byte not zero without byte_valid");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_index_reg <= EXT64_BYTES)
        else $error("header index out of range");

    a_payload_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAYLOAD && bytes_remaining_reg != 64'd0
        |=> bytes_remaining_reg == $past(bytes_remaining_reg) - 64'd1)
        else $error("payload counter did not step");
`endif

endmodule

### hdl/wsfd_out_stage.sv
`timescale 1ns / 1ps

module wsfd_out_stage
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       has_result,
    input  result_t    result,
    output logic       advance,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic       frame_done,
    output logic [1:0] status
);

    logic    res_valid_reg;
    result_t res_reg;

    // Move on when the result register is empty or being taken
    assign advance = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid && has_result;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (advance && item_valid && has_result)
        begin
            res_reg <= result;
        end
    end

    assign res_valid    = res_valid_reg;
    assign payload_byte = res_reg.payload_byte;
    assign byte_valid   = res_reg.byte_valid;
    assign frame_done   = res_reg.frame_done;
    assign status       = res_reg.status;

endmodule

### hdl/websocket_frame_decoder.sv
`timescale 1ns / 1ps

// WebSocket frame decoder, text frames only.
// Receive channel: rx_valid / rx_stall carry data_byte and chunk_last, one
// byte of a received chunk per request; chunk_last marks its final byte.
// Result channel: res_valid / res_stall carry payload_byte, byte_valid,
// frame_done and status. Header and mask key bytes give no result unless
// the frame ends there; payload bytes come out unmasked. A result with
// frame_done ends the frame; a status other than ok tells the receiver to
// discard bytes already delivered for it. Trailing bytes are dropped.
// Throughput: one byte per cycle while the receiver does not stall. A byte
// is registered in the input register and its result in the result
// register. The per-byte update (64-bit count down, key XOR) is the
// path between the input and result registers.
// Reset empties both registers and returns the parser to the first header
// byte. While the receiver stalls, the result is held, at most one more
// byte is taken into the input register, then rx_stall rises.
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] data_byte,
    input  logic       chunk_last,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] payload_byte,
    output logic       byte_valid,
    output logic       frame_done,
    output logic [1:0] status
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    has_result;
    result_t result;

    wsfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .data_byte  (data_byte),
        .chunk_last (chunk_last),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wsfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    wsfd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .has_result   (has_result),
        .result       (result),
        .advance      (advance),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .frame_done   (frame_done),
        .status       (status)
    );

endmodule

### test/wsfd_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the frame decoder, predicts each result from the
// accepted bytes and compares it field by field with what comes out.
module wsfd_frame_checker
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  logic [7:0]  data_byte,
    input  logic        chunk_last,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [7:0]  payload_byte,
    input  logic        byte_valid,
    input  logic        frame_done,
    input  logic [1:0]  status,
    output logic [31:0] fail_count,
    output logic [31:0] pending
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_SKIP
    } parse_phase_t;

    // Parser state as the decoder should hold it
    parse_phase_t phase;
    logic [3:0]   hdr_count;
    logic         is_text;
    logic         masked;
    logic [63:0]  frame_len;
    logic [31:0]  key;
    logic [63:0]  bytes_left;
    logic [1:0]   key_pos;

    result_t      expected_results[$];
    int           errors;

    // Count and report a mismatch
    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Close the header once the length is complete: opcode first, then mask bit
    task automatic header_done(input logic last, output logic fin, output logic [1:0] st);
        fin = 1'b1;
        if (!is_text)
            st = ST_NOT_TEXT;
        else if (!masked)
            st = ST_NOT_MASKED;
        else
        begin
            phase     = PH_MASK;
            hdr_count = '0;
            fin       = last;
            st        = ST_TRUNC;
        end
    endtask

    // Advance the parser by one byte and queue the result it causes, if any
    task automatic decode_byte(input logic [7:0] b, input logic last);
        result_t    r;
        logic       fin;
        logic [1:0] st;
        r   = '0;
        fin = 1'b0;
        st  = ST_OK;
        case (phase)
            PH_HDR0:
            begin
                is_text    = (b[3:0] == OPCODE_TEXT);
                masked     = 1'b0;
                frame_len  = '0;
                key        = '0;
                bytes_left = '0;
                key_pos    = '0;
                hdr_count  = '0;
                phase      = PH_HDR1;
                fin        = last;
                st         = ST_TRUNC;
            end
            PH_HDR1:
            begin
                masked = b[7];
                if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64)
                begin
                    hdr_count = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    frame_len = '0;
                    phase     = PH_EXTLEN;
                    fin       = last;
                    st        = ST_TRUNC;
                end
                else
                begin
                    frame_len = {57'd0, b[6:0]};
                    header_done(last, fin, st);
                end
            end
            PH_EXTLEN:
            begin
                // Big-endian length, shifted in as an unsigned value
                frame_len = {frame_len[55:0], b};
                hdr_count = hdr_count - 4'd1;
                if (hdr_count == 4'd0)
                    header_done(last, fin, st);
                else
                begin
                    fin = last;
                    st  = ST_TRUNC;
                end
            end
            PH_MASK:
            begin
                key       = {key[23:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= MASK_BYTES)
                begin
                    bytes_left = frame_len;
                    key_pos    = '0;
                    if (bytes_left == 64'd0)
                        fin = 1'b1;
                    else
                        phase = PH_PAYLOAD;
                end
                if (!fin && last)
                begin
                    fin = 1'b1;
                    st  = ST_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                if (bytes_left == 64'd0)
                    fin = 1'b1;
                else
                begin
                    // Unmask with the rotating key, key byte 0 first
                    r.payload_byte = b ^ key[8 * (3 - key_pos) +: 8];
                    r.byte_valid   = 1'b1;
                    key_pos        = key_pos + 2'd1;
                    bytes_left     = bytes_left - 64'd1;
                    if (bytes_left == 64'd0)
                        fin = 1'b1;
                    else if (last)
                    begin
                        r   = '0;
                        fin = 1'b1;
                        st  = ST_TRUNC;
                    end
                    else
                        expected_results.push_back(r);
                end
            end
            default:
            begin
                if (last)
                    phase = PH_HDR0;
            end
        endcase
        if (fin)
        begin
            r.frame_done = 1'b1;
            r.status     = st;
            phase        = last ? PH_HDR0 : PH_SKIP;
            expected_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            phase      = PH_HDR0;
            hdr_count  = '0;
            is_text    = 1'b0;
            masked     = 1'b0;
            frame_len  = '0;
            key        = '0;
            bytes_left = '0;
            key_pos    = '0;
            expected_results.delete();
            errors     = 0;
            fail_count <= '0;
            pending    <= '0;
        end
        else
        begin
            // Check a result request against the oldest expectation
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $error("extra result: byte %0h valid %0b done %0b status %0d",
                           payload_byte, byte_valid, frame_done, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("payload_byte", want.payload_byte, payload_byte);
                    compare_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, byte_valid});
                    compare_field("frame_done", {7'd0, want.frame_done}, {7'd0, frame_done});
                    compare_field("status", {6'd0, want.status}, {6'd0, status});
                end
            end
            // Predict from an accepted byte request
            if (rx_valid && !rx_stall)
                decode_byte(data_byte, chunk_last);
            fail_count <= errors;
            pending    <= expected_results.size();
        end
    end

endmodule

### test/tb_websocket_frame_decoder.sv
`timescale 1ns / 1ps

module tb_websocket_frame_decoder;
    import wsfd_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        rx_valid   = 1'b0;
    logic        rx_stall;
    logic [7:0]  data_byte  = 8'd0;
    logic        chunk_last = 1'b0;
    logic        res_valid;
    logic        res_stall  = 1'b0;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_done;
    logic [1:0]  status;
    logic [31:0] fail_count;
    logic [31:0] pending;

    logic [7:0]  chunk_bytes[$];
    logic        quiet      = 1'b0;
    int          items_done = 0;
    int          cycles     = 0;
    int          stall_left = 0;

    websocket_frame_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .data_byte    (data_byte),
        .chunk_last   (chunk_last),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .frame_done   (frame_done),
        .status       (status)
    );

    wsfd_frame_checker u_frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .data_byte    (data_byte),
        .chunk_last   (chunk_last),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .payload_byte (payload_byte),
        .byte_valid   (byte_valid),
        .frame_done   (frame_done),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_websocket_frame_decoder: errors");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the result side in bursts
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            res_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            res_stall  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Offer one byte request after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid   <= 1'b1;
        data_byte  <= b;
        chunk_last <= last;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
    endtask

    // Send the queued chunk, flagging its final byte
    task automatic send_chunk();
        items_done += chunk_bytes.size();
        foreach (chunk_bytes[i])
            send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
        chunk_bytes.delete();
    endtask

    // Build and send one random chunk: mostly frames, some noise, some cut short
    task automatic random_chunk();
        logic [63:0] len;
        logic [31:0] key;
        logic [6:0]  len7;
        logic [3:0]  op;
        logic        mask_bit;
        int          enc;
        int          body;
        int          cut;
        int          n;
        quiet <= ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 80)
        begin
            // Pick the length and the way it is encoded
            enc = $urandom_range(0, 99);
            if (enc < 60)
            begin
                len  = 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
                                                       : $urandom_range(0, 16));
                len7 = len[6:0];
            end
            else if (enc < 85)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = 64'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 300));
                else
                    len = 64'($urandom_range(0, 24));
                len7 = LEN7_EXT16;
            end
            else
            begin
                len  = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 24));
                len7 = LEN7_EXT64;
            end
            op       = ($urandom_range(0, 11) == 0) ? 4'($urandom) : OPCODE_TEXT;
            mask_bit = ($urandom_range(0, 19) != 0);
            chunk_bytes.push_back({4'($urandom), op});
            chunk_bytes.push_back({mask_bit, len7});
            if (len7 == LEN7_EXT16)
                for (n = 1; n >= 0; n--)
                    chunk_bytes.push_back(len[8 * n +: 8]);
            else if (len7 == LEN7_EXT64)
                for (n = 7; n >= 0; n--)
                    chunk_bytes.push_back(len[8 * n +: 8]);
            key = $urandom;
            for (n = 3; n >= 0; n--)
                chunk_bytes.push_back(key[8 * n +: 8]);
            // A chunk cannot carry a huge payload: send only a few bytes of it
            body = (len > 64'd400) ? int'($urandom_range(0, 12)) : int'(len);
            repeat (body)
                chunk_bytes.push_back(8'($urandom));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
            repeat (n)
                chunk_bytes.push_back(8'($urandom));
        end
        else
        begin
            // Noise: random header and body bytes
            n = $urandom_range(1, 14);
            repeat (n)
                chunk_bytes.push_back(8'($urandom));
        end
        // Cut the chunk short now and then
        if ($urandom_range(0, 99) < 20)
        begin
            cut = $urandom_range(1, chunk_bytes.size());
            while (chunk_bytes.size() > cut)
                void'(chunk_bytes.pop_back());
        end
        send_chunk();
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // Chunk ends after the first header byte
        chunk_bytes = '{8'h81};
        send_chunk();
        // Binary opcode
        chunk_bytes = '{8'h82, 8'h80};
        send_chunk();
        // Text frame with the mask bit clear
        chunk_bytes = '{8'h01, 8'h05};
        send_chunk();
        // Chunk ends inside the 16-bit length
        chunk_bytes = '{8'h81, 8'hFE, 8'h00};
        send_chunk();
        // Empty masked payload ends on the last key byte
        chunk_bytes = '{8'h81, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_chunk();
        // One payload byte, then a trailing byte to drop
        chunk_bytes = '{8'h81, 8'h81, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hAA, 8'h55};
        send_chunk();

        while (items_done < ITEM_TARGET)
            random_chunk();
        rx_valid <= 1'b0;

        // Drain, then allow for the pipeline
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb_websocket_frame_decoder: clean");
        else
            $display("tb_websocket_frame_decoder: errors");
        $finish;
    end

endmodule

### websocket_frame_decoder.f
hdl/wsfd_pkg.sv
hdl/wsfd_in_stage.sv
hdl/wsfd_parser.sv
hdl/wsfd_out_stage.sv
hdl/websocket_frame_decoder.sv
test/wsfd_frame_checker.sv
test/tb_websocket_frame_decoder.sv
